>>> rtl/rdrp_pkg.sv
// Shared types and constants for the rotate-drive-rotate PID sequencer.
package rdrp_pkg;

    localparam int FRAC_BITS      = 12;
    localparam int DT_STEP        = 6554;
    localparam int TIMEOUT_TICKS  = 50;
    localparam int CONVERGE_TICKS = 10;

    localparam int YAW_BIG  = (785 * (1 << FRAC_BITS) + 500) / 1000;
    localparam int YAW_CAP  = (300 * (1 << FRAC_BITS) + 500) / 1000;
    localparam int DIST_CAP = (100 * (1 << FRAC_BITS) + 500) / 1000;
    localparam int DIST_MIN = (50 * (1 << FRAC_BITS) + 500) / 1000;
    localparam int KI_PONLY = (300 * (1 << FRAC_BITS) + 500) / 1000;

    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_TICK    = 2'd1,
        ACT_CANCEL  = 2'd2,
        ACT_PREEMPT = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        PHASE_ROTATE   = 2'd0,
        PHASE_STRAIGHT = 2'd1,
        PHASE_ALIGN    = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        OUT_RUNNING   = 3'd0,
        OUT_DONE      = 3'd1,
        OUT_TIMEOUT   = 3'd2,
        OUT_PREEMPTED = 3'd3,
        OUT_CANCELLED = 3'd4
    } outcome_t;

    typedef enum logic [2:0] {
        CFG_KP_YAW       = 3'd0,
        CFG_KI_YAW       = 3'd1,
        CFG_KD_YAW       = 3'd2,
        CFG_KP_DISTANCE  = 3'd3,
        CFG_KI_DISTANCE  = 3'd4,
        CFG_KD_DISTANCE  = 3'd5,
        CFG_YAW_TOL      = 3'd6,
        CFG_DISTANCE_TOL = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] kd;
    } pid_gains_t;

endpackage

>>> rtl/rdrp_yaw_pid.sv
// Yaw PID datapath with integral update and tolerance check.
module rdrp_yaw_pid (
    input  rdrp_pkg::pid_gains_t gains,
    input  logic signed [14:0]   err,
    input  logic signed [31:0]   integ,
    input  logic signed [15:0]   prev,
    input  logic        [13:0]   tol,
    output logic signed [11:0]   ref_out,
    output logic signed [31:0]   integ_next,
    output logic                 within_tol
);
    import rdrp_pkg::*;

    localparam logic signed [38:0] CAP_POS = 39'(YAW_CAP);
    localparam logic signed [38:0] CAP_NEG = -39'(YAW_CAP);

    logic signed [15:0] err_ext;
    logic        [15:0] err_abs;
    logic               small_err;
    logic signed [32:0] p_term;
    logic signed [48:0] i_term;
    logic signed [16:0] diff;
    logic signed [33:0] d_term;
    logic signed [50:0] sum;
    logic signed [38:0] shifted;
    logic signed [38:0] clamped;
    logic signed [32:0] dt_prod;
    logic signed [16:0] inc;
    logic signed [32:0] integ_sum;
    logic signed [31:0] integ_sat;

    assign err_ext    = 16'(err);
    assign err_abs    = err_ext[15] ? 16'(-err_ext) : err_ext;
    assign small_err  = err_abs <= 16'(YAW_BIG);
    assign within_tol = err_abs < {2'b00, tol};

    assign p_term = $signed({1'b0, gains.kp}) * err_ext;
    assign i_term = $signed({1'b0, gains.ki}) * integ;
    assign diff   = 17'(err_ext) - 17'(prev);
    assign d_term = $signed({1'b0, gains.kd}) * diff;

    assign sum     = small_err ? 51'(p_term) + 51'(i_term) + 51'(d_term) : 51'(p_term);
    assign shifted = 39'(sum >>> FRAC_BITS);

    always_comb begin
        if (shifted > CAP_POS) begin
            clamped = CAP_POS;
        end else if (shifted < CAP_NEG) begin
            clamped = CAP_NEG;
        end else begin
            clamped = shifted;
        end
    end

    assign ref_out = clamped[11:0];

    assign dt_prod   = 33'(err_ext) * $signed({1'b0, 16'(DT_STEP)});
    assign inc       = 17'(dt_prod >>> 16);
    assign integ_sum = 33'(integ) + 33'(inc);

    always_comb begin
        if (integ_sum > 33'sh0_7FFF_FFFF) begin
            integ_sat = 32'sh7FFF_FFFF;
        end else if (integ_sum < -33'sh0_8000_0000) begin
            integ_sat = 32'sh8000_0000;
        end else begin
            integ_sat = integ_sum[31:0];
        end
    end

    assign integ_next = small_err ? integ_sat : integ;

endmodule

>>> rtl/rdrp_dist_pid.sv
// Distance PID datapath with double integration (single when P-only) and the minimum speed rule.
module rdrp_dist_pid (
    input  rdrp_pkg::pid_gains_t gains,
    input  logic signed [17:0]   dist_err,
    input  logic signed [31:0]   integ,
    input  logic signed [17:0]   prev,
    input  logic        [16:0]   tol,
    output logic signed [9:0]    ref_out,
    output logic signed [31:0]   integ_next,
    output logic                 within_tol
);
    import rdrp_pkg::*;

    localparam logic signed [38:0] CAP_POS = 39'(DIST_CAP);
    localparam logic signed [38:0] CAP_NEG = -39'(DIST_CAP);
    localparam logic signed [38:0] MIN_POS = 39'(DIST_MIN);
    localparam logic signed [38:0] MIN_NEG = -39'(DIST_MIN);
    localparam logic signed [32:0] SAT_HI  = 33'sh0_7FFF_FFFF;
    localparam logic signed [32:0] SAT_LO  = -33'sh0_8000_0000;

    logic        [17:0] dist_abs;
    logic               p_only;
    logic signed [34:0] p_term;
    logic signed [48:0] i_term;
    logic signed [18:0] diff;
    logic signed [35:0] d_term;
    logic signed [50:0] sum;
    logic signed [38:0] shifted;
    logic signed [38:0] clamped;
    logic signed [38:0] floored;
    logic signed [35:0] dt_prod;
    logic signed [19:0] inc;
    logic signed [32:0] once_sum;
    logic signed [31:0] once_sat;
    logic signed [32:0] twice_sum;
    logic signed [31:0] twice_sat;

    assign dist_abs   = dist_err[17] ? 18'(-dist_err) : dist_err;
    assign within_tol = dist_abs < {1'b0, tol};
    assign p_only     = gains.ki >= 16'(KI_PONLY);

    assign p_term = $signed({1'b0, gains.kp}) * dist_err;
    assign i_term = $signed({1'b0, gains.ki}) * integ;
    assign diff   = 19'(dist_err) - 19'(prev);
    assign d_term = $signed({1'b0, gains.kd}) * diff;

    assign sum     = p_only ? 51'(p_term) : 51'(p_term) + 51'(i_term) + 51'(d_term);
    assign shifted = 39'(sum >>> FRAC_BITS);

    always_comb begin
        if (shifted > CAP_POS) begin
            clamped = CAP_POS;
        end else if (shifted < CAP_NEG) begin
            clamped = CAP_NEG;
        end else begin
            clamped = shifted;
        end
        if (!clamped[38]) begin
            floored = (clamped < MIN_POS) ? MIN_POS : clamped;
        end else begin
            floored = (clamped > MIN_NEG) ? MIN_NEG : clamped;
        end
    end

    assign ref_out = floored[9:0];

    assign dt_prod   = 36'(dist_err) * $signed({1'b0, 16'(DT_STEP)});
    assign inc       = 20'(dt_prod >>> 16);
    assign once_sum  = 33'(integ) + 33'(inc);

    always_comb begin
        if (once_sum > SAT_HI) begin
            once_sat = 32'sh7FFF_FFFF;
        end else if (once_sum < SAT_LO) begin
            once_sat = 32'sh8000_0000;
        end else begin
            once_sat = once_sum[31:0];
        end
    end

    assign twice_sum = 33'(once_sat) + 33'(inc);

    always_comb begin
        if (twice_sum > SAT_HI) begin
            twice_sat = 32'sh7FFF_FFFF;
        end else if (twice_sum < SAT_LO) begin
            twice_sat = 32'sh8000_0000;
        end else begin
            twice_sat = twice_sum[31:0];
        end
    end

    assign integ_next = p_only ? once_sat : twice_sat;

endmodule

>>> rtl/rotate_drive_rotate_pid_sequencer.sv
// Top level of the rotate-drive-rotate PID sequencer with its handshake and run state.
// A result passes from the input register through the PID datapath into the result register.
// Throughput: one item per cycle while m_ready does not stall the output; the run state
// closes through the PID datapath on each accepted item.
// Reset (aresetn low, synchronous) clears the run state, empties both registers and loads
// the default gains and tolerances.
module rotate_drive_rotate_pid_sequencer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_wr_index,
    input  logic [16:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_action,
    input  logic signed [14:0] s_yaw_to_target,
    input  logic signed [17:0] s_distance_ahead,
    input  logic signed [14:0] s_goal_yaw_error,
    input  logic               s_plan_valid,
    input  logic signed [15:0] s_plan_linear,
    input  logic signed [15:0] s_plan_angular,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_phase,
    output logic signed [9:0]  m_ref_linear,
    output logic signed [11:0] m_ref_angular,
    output logic signed [15:0] m_cmd_linear,
    output logic signed [15:0] m_cmd_angular,
    output logic [2:0]         m_outcome
);
    import rdrp_pkg::*;

    pid_gains_t  yaw_gains_reg;
    pid_gains_t  dist_gains_reg;
    logic [13:0] yaw_tol_reg;
    logic [16:0] dist_tol_reg;

    logic               in_valid_reg;
    action_t            in_action_reg;
    logic signed [14:0] in_yaw_reg;
    logic signed [17:0] in_dist_reg;
    logic signed [14:0] in_goal_reg;
    logic               in_plan_valid_reg;
    logic signed [15:0] in_plan_linear_reg;
    logic signed [15:0] in_plan_angular_reg;

    logic               out_valid_reg;
    logic [1:0]         out_phase_reg;
    logic signed [9:0]  out_ref_linear_reg;
    logic signed [11:0] out_ref_angular_reg;
    logic signed [15:0] out_cmd_linear_reg;
    logic signed [15:0] out_cmd_angular_reg;
    outcome_t           out_outcome_reg;

    logic               run_active_reg, run_active_next;
    phase_t             phase_reg, phase_next;
    logic signed [31:0] yaw_integral_reg, yaw_integral_next;
    logic signed [31:0] distance_integral_reg, distance_integral_next;
    logic signed [15:0] previous_yaw_reg, previous_yaw_next;
    logic signed [17:0] previous_distance_reg, previous_distance_next;
    logic [3:0]         yaw_hits_reg, yaw_hits_next;
    logic [3:0]         distance_hits_reg, distance_hits_next;
    logic [3:0]         goal_hits_reg, goal_hits_next;
    logic [7:0]         stale_ticks_reg, stale_ticks_next;

    logic               advance;
    logic               out_free;
    logic signed [14:0] yaw_err;
    logic signed [11:0] yaw_ref;
    logic signed [31:0] yaw_integ_upd;
    logic               yaw_within;
    logic signed [9:0]  dist_ref;
    logic signed [31:0] dist_integ_upd;
    logic               dist_within;
    logic [3:0]         yaw_hits_bump;
    logic [3:0]         distance_hits_bump;
    logic [3:0]         goal_hits_bump;
    logic [7:0]         stale_bump;
    logic               done;

    logic [1:0]         res_phase;
    logic signed [9:0]  res_ref_linear;
    logic signed [11:0] res_ref_angular;
    logic signed [15:0] res_cmd_linear;
    logic signed [15:0] res_cmd_angular;
    outcome_t           res_outcome;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yaw_gains_reg  <= '{kp: 16'd410, ki: 16'd4096, kd: 16'd0};
            dist_gains_reg <= '{kp: 16'd410, ki: 16'd4096, kd: 16'd0};
            yaw_tol_reg    <= 14'd205;
            dist_tol_reg   <= 17'd205;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_wr_index))
                CFG_KP_YAW:       yaw_gains_reg.kp  <= cfg_wr_data[15:0];
                CFG_KI_YAW:       yaw_gains_reg.ki  <= cfg_wr_data[15:0];
                CFG_KD_YAW:       yaw_gains_reg.kd  <= cfg_wr_data[15:0];
                CFG_KP_DISTANCE:  dist_gains_reg.kp <= cfg_wr_data[15:0];
                CFG_KI_DISTANCE:  dist_gains_reg.ki <= cfg_wr_data[15:0];
                CFG_KD_DISTANCE:  dist_gains_reg.kd <= cfg_wr_data[15:0];
                CFG_YAW_TOL:      yaw_tol_reg       <= cfg_wr_data[13:0];
                CFG_DISTANCE_TOL: dist_tol_reg      <= cfg_wr_data;
                default:          dist_tol_reg      <= dist_tol_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg       <= action_t'(s_action);
            in_yaw_reg          <= s_yaw_to_target;
            in_dist_reg         <= s_distance_ahead;
            in_goal_reg         <= s_goal_yaw_error;
            in_plan_valid_reg   <= s_plan_valid;
            in_plan_linear_reg  <= s_plan_linear;
            in_plan_angular_reg <= s_plan_angular;
        end
    end

    assign yaw_err = (phase_reg == PHASE_ROTATE) ? in_yaw_reg : in_goal_reg;

    rdrp_yaw_pid u_yaw_pid (
        .gains      (yaw_gains_reg),
        .err        (yaw_err),
        .integ      (yaw_integral_reg),
        .prev       (previous_yaw_reg),
        .tol        (yaw_tol_reg),
        .ref_out    (yaw_ref),
        .integ_next (yaw_integ_upd),
        .within_tol (yaw_within)
    );

    rdrp_dist_pid u_dist_pid (
        .gains      (dist_gains_reg),
        .dist_err   (in_dist_reg),
        .integ      (distance_integral_reg),
        .prev       (previous_distance_reg),
        .tol        (dist_tol_reg),
        .ref_out    (dist_ref),
        .integ_next (dist_integ_upd),
        .within_tol (dist_within)
    );

    assign yaw_hits_bump      = (yaw_hits_reg == 4'hF) ? 4'hF : yaw_hits_reg + 4'd1;
    assign distance_hits_bump = (distance_hits_reg == 4'hF) ? 4'hF : distance_hits_reg + 4'd1;
    assign goal_hits_bump     = (goal_hits_reg == 4'hF) ? 4'hF : goal_hits_reg + 4'd1;
    assign stale_bump         = (stale_ticks_reg == 8'hFF) ? 8'hFF : stale_ticks_reg + 8'd1;

    always_comb begin
        run_active_next        = run_active_reg;
        phase_next             = phase_reg;
        yaw_integral_next      = yaw_integral_reg;
        distance_integral_next = distance_integral_reg;
        previous_yaw_next      = previous_yaw_reg;
        previous_distance_next = previous_distance_reg;
        yaw_hits_next          = yaw_hits_reg;
        distance_hits_next     = distance_hits_reg;
        goal_hits_next         = goal_hits_reg;
        stale_ticks_next       = stale_ticks_reg;
        done                   = 1'b0;
        res_phase              = phase_reg;
        res_ref_linear         = '0;
        res_ref_angular        = '0;
        res_cmd_linear         = '0;
        res_cmd_angular        = '0;
        res_outcome            = OUT_RUNNING;

        unique case (in_action_reg) inside
            ACT_START: begin
                run_active_next        = 1'b1;
                phase_next             = PHASE_ROTATE;
                yaw_integral_next      = '0;
                distance_integral_next = '0;
                previous_yaw_next      = '0;
                previous_distance_next = '0;
                yaw_hits_next          = '0;
                distance_hits_next     = '0;
                goal_hits_next         = '0;
                stale_ticks_next       = '0;
                res_phase              = PHASE_ROTATE;
            end
            ACT_CANCEL, ACT_PREEMPT: begin
                run_active_next = 1'b0;
                res_outcome     = (in_action_reg == ACT_CANCEL) ? OUT_CANCELLED : OUT_PREEMPTED;
            end
            ACT_TICK: begin
                if (run_active_reg) begin
                    if (phase_reg == PHASE_ROTATE) begin
                        res_ref_angular   = yaw_ref;
                        yaw_integral_next = yaw_integ_upd;
                        previous_yaw_next = 16'(yaw_err);
                        if (yaw_within) begin
                            yaw_hits_next = yaw_hits_bump;
                            if (yaw_hits_bump > 4'(CONVERGE_TICKS)) begin
                                phase_next = PHASE_STRAIGHT;
                            end
                        end
                    end else if (phase_reg == PHASE_STRAIGHT) begin
                        res_ref_linear         = dist_ref;
                        distance_integral_next = dist_integ_upd;
                        previous_distance_next = in_dist_reg;
                        if (dist_within) begin
                            distance_hits_next = distance_hits_bump;
                            if (distance_hits_bump > 4'(CONVERGE_TICKS)) begin
                                phase_next        = PHASE_ALIGN;
                                yaw_integral_next = '0;
                                previous_yaw_next = '0;
                            end
                        end
                    end else begin
                        res_ref_angular   = yaw_ref;
                        yaw_integral_next = yaw_integ_upd;
                        previous_yaw_next = 16'(yaw_err);
                        if (yaw_within) begin
                            goal_hits_next = goal_hits_bump;
                            if (goal_hits_bump > 4'(CONVERGE_TICKS)) begin
                                done = 1'b1;
                            end
                        end
                    end

                    if (done) begin
                        res_outcome     = OUT_DONE;
                        run_active_next = 1'b0;
                    end else if (!in_plan_valid_reg) begin
                        stale_ticks_next = stale_bump;
                        if (stale_bump >= 8'(TIMEOUT_TICKS)) begin
                            res_outcome     = OUT_TIMEOUT;
                            run_active_next = 1'b0;
                        end
                    end else begin
                        stale_ticks_next = '0;
                        res_cmd_linear   = in_plan_linear_reg;
                        res_cmd_angular  = in_plan_angular_reg;
                    end
                end
            end
            default: begin
                run_active_next = run_active_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_active_reg        <= 1'b0;
            phase_reg             <= PHASE_ROTATE;
            yaw_integral_reg      <= '0;
            distance_integral_reg <= '0;
            previous_yaw_reg      <= '0;
            previous_distance_reg <= '0;
            yaw_hits_reg          <= '0;
            distance_hits_reg     <= '0;
            goal_hits_reg         <= '0;
            stale_ticks_reg       <= '0;
        end else if (advance) begin
            run_active_reg        <= run_active_next;
            phase_reg             <= phase_next;
            yaw_integral_reg      <= yaw_integral_next;
            distance_integral_reg <= distance_integral_next;
            previous_yaw_reg      <= previous_yaw_next;
            previous_distance_reg <= previous_distance_next;
            yaw_hits_reg          <= yaw_hits_next;
            distance_hits_reg     <= distance_hits_next;
            goal_hits_reg         <= goal_hits_next;
            stale_ticks_reg       <= stale_ticks_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_phase_reg       <= res_phase;
            out_ref_linear_reg  <= res_ref_linear;
            out_ref_angular_reg <= res_ref_angular;
            out_cmd_linear_reg  <= res_cmd_linear;
            out_cmd_angular_reg <= res_cmd_angular;
            out_outcome_reg     <= res_outcome;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_phase       = out_phase_reg;
    assign m_ref_linear  = out_ref_linear_reg;
    assign m_ref_angular = out_ref_angular_reg;
    assign m_cmd_linear  = out_cmd_linear_reg;
    assign m_cmd_angular = out_cmd_angular_reg;
    assign m_outcome     = out_outcome_reg;

`ifndef ASSERT_OFF
    a_ref_linear_only_straight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_ref_linear != '0) |-> m_phase == PHASE_STRAIGHT)
        else $error("Linear reference reported outside the straight phase.");

    a_ref_angular_not_straight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_ref_angular != '0) |-> m_phase != PHASE_STRAIGHT)
        else $error("Angular reference reported in the straight phase.");

    a_cmd_zero_when_ended: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_outcome != OUT_RUNNING) |-> (m_cmd_linear == '0) && (m_cmd_angular == '0))
        else $error("Nonzero command with a terminal outcome.");

    a_rotate_converged: assert property (@(posedge aclk) disable iff (!aresetn)
        run_active_reg && (yaw_hits_reg > 4'(CONVERGE_TICKS)) |-> phase_reg != PHASE_ROTATE)
        else $error("Rotation converged but the phase did not advance.");

    a_timeout_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        stale_ticks_reg >= 8'(TIMEOUT_TICKS) |-> !run_active_reg)
        else $error("Run still active after the stale plan timeout.");
`endif

endmodule

>>> test/tb.sv
// Testbench for the rotate-drive-rotate PID sequencer: directed and random ticks against a predictor.
`timescale 1ns / 1ps

module tb;
    import rdrp_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int STALL_CYCLES = 120;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    typedef struct {
        action_t            action;
        logic signed [14:0] yaw;
        logic signed [17:0] ahead;
        logic signed [14:0] goal;
        logic               plan_ok;
        logic signed [15:0] lin;
        logic signed [15:0] ang;
    } tick_item_t;

    typedef struct {
        phase_t             phase;
        logic signed [9:0]  ref_lin;
        logic signed [11:0] ref_ang;
        logic signed [15:0] cmd_lin;
        logic signed [15:0] cmd_ang;
        outcome_t           outcome;
    } tick_result_t;

    typedef struct {
        logic [15:0] kp_y, ki_y, kd_y, kp_d, ki_d, kd_d;
        logic [13:0] ytol;
        logic [16:0] dtol;
    } gain_set_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [2:0]         cfg_wr_index;
    logic [16:0]        cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_action;
    logic signed [14:0] s_yaw_to_target;
    logic signed [17:0] s_distance_ahead;
    logic signed [14:0] s_goal_yaw_error;
    logic               s_plan_valid;
    logic signed [15:0] s_plan_linear;
    logic signed [15:0] s_plan_angular;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_phase;
    logic signed [9:0]  m_ref_linear;
    logic signed [11:0] m_ref_angular;
    logic signed [15:0] m_cmd_linear;
    logic signed [15:0] m_cmd_angular;
    logic [2:0]         m_outcome;

    rotate_drive_rotate_pid_sequencer uut (.*);

    always #5 aclk = ~aclk;

    // Predictor copy of the configuration and the run state.
    longint gain_kp_yaw = 410, gain_ki_yaw = 4096, gain_kd_yaw = 0;
    longint gain_kp_dist = 410, gain_ki_dist = 4096, gain_kd_dist = 0;
    longint tol_yaw = 205, tol_dist = 205;
    bit     run_on = 0;
    int     ph = 0;
    longint yaw_acc = 0, dist_acc = 0, yaw_prev = 0, dist_prev = 0;
    int     yaw_hits = 0, dist_hits = 0, goal_hits = 0, stale = 0;

    tick_result_t tick_results_due[$];
    int           errors = 0;
    int           items_sent = 0;
    int           cycle_count = 0;
    bit           steady = 0;
    bit           stall_request = 0;
    int           stall_left = 0;

    function automatic longint sat32(longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    function automatic int bump(int c);
        return (c < 15) ? c + 1 : 15;
    endfunction

    function longint yaw_loop(longint e);
        longint sum, mag, out;
        bit near;
        mag = (e < 0) ? -e : e;
        near = (mag <= YAW_BIG);
        sum = gain_kp_yaw * e;
        if (near) sum += gain_ki_yaw * yaw_acc + gain_kd_yaw * (e - yaw_prev);
        out = sum >>> FRAC_BITS;
        if (out > YAW_CAP) out = YAW_CAP;
        else if (out < -YAW_CAP) out = -YAW_CAP;
        if (near) yaw_acc = sat32(yaw_acc + ((e * DT_STEP) >>> 16));
        yaw_prev = e;
        return out;
    endfunction

    function longint distance_loop(longint d);
        longint sum, out, step;
        bit ponly;
        ponly = (gain_ki_dist >= KI_PONLY);
        sum = gain_kp_dist * d;
        if (!ponly) sum += gain_ki_dist * dist_acc + gain_kd_dist * (d - dist_prev);
        out = sum >>> FRAC_BITS;
        if (out > DIST_CAP) out = DIST_CAP;
        else if (out < -DIST_CAP) out = -DIST_CAP;
        if (out >= 0) begin
            if (out < DIST_MIN) out = DIST_MIN;
        end else if (out > -DIST_MIN) begin
            out = -DIST_MIN;
        end
        step = (d * DT_STEP) >>> 16;
        if (!ponly) dist_acc = sat32(dist_acc + step);
        dist_acc = sat32(dist_acc + step);
        dist_prev = d;
        return out;
    endfunction

    function tick_result_t sequencer_tick(tick_item_t it);
        tick_result_t res;
        longint lin, ang, e;
        bit finished;
        lin = 0;
        ang = 0;
        finished = 0;
        res.phase = phase_t'(ph);
        res.cmd_lin = '0;
        res.cmd_ang = '0;
        res.outcome = OUT_RUNNING;
        case (it.action)
            ACT_START: begin
                ph = 0;
                yaw_acc = 0;
                dist_acc = 0;
                yaw_prev = 0;
                dist_prev = 0;
                yaw_hits = 0;
                dist_hits = 0;
                goal_hits = 0;
                stale = 0;
                run_on = 1;
                res.phase = PHASE_ROTATE;
            end
            ACT_CANCEL: begin
                res.outcome = OUT_CANCELLED;
                run_on = 0;
            end
            ACT_PREEMPT: begin
                res.outcome = OUT_PREEMPTED;
                run_on = 0;
            end
            default: begin
                if (run_on) begin
                    if (ph == 0) begin
                        e = it.yaw;
                        ang = yaw_loop(e);
                        if (((e < 0) ? -e : e) < tol_yaw) begin
                            yaw_hits = bump(yaw_hits);
                            if (yaw_hits > CONVERGE_TICKS) ph = 1;
                        end
                    end else if (ph == 1) begin
                        e = it.ahead;
                        lin = distance_loop(e);
                        if (((e < 0) ? -e : e) < tol_dist) begin
                            dist_hits = bump(dist_hits);
                            if (dist_hits > CONVERGE_TICKS) begin
                                ph = 2;
                                yaw_acc = 0;
                                yaw_prev = 0;
                            end
                        end
                    end else begin
                        e = it.goal;
                        ang = yaw_loop(e);
                        if (((e < 0) ? -e : e) < tol_yaw) begin
                            goal_hits = bump(goal_hits);
                            if (goal_hits > CONVERGE_TICKS) finished = 1;
                        end
                    end
                    if (finished) begin
                        res.outcome = OUT_DONE;
                        run_on = 0;
                    end else if (!it.plan_ok) begin
                        if (stale < 255) stale++;
                        if (stale >= TIMEOUT_TICKS) begin
                            res.outcome = OUT_TIMEOUT;
                            run_on = 0;
                        end
                    end else begin
                        stale = 0;
                        res.cmd_lin = it.lin;
                        res.cmd_ang = it.ang;
                    end
                end
            end
        endcase
        res.ref_lin = lin[9:0];
        res.ref_ang = ang[11:0];
        return res;
    endfunction

    function automatic tick_item_t mk_item(action_t a, int yaw, int ahead, int goal,
                                           bit plan_ok, int lin, int ang);
        tick_item_t it;
        it.action = a;
        it.yaw = 15'(yaw);
        it.ahead = 18'(ahead);
        it.goal = 15'(goal);
        it.plan_ok = plan_ok;
        it.lin = 16'(lin);
        it.ang = 16'(ang);
        return it;
    endfunction

    function automatic int rand_span(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int pick_error(longint tol, int lo, int hi);
        int r;
        r = int'($urandom_range(99));
        if (r < 5) return $urandom_range(1) ? hi : lo;
        if (r < 70) return (tol > 0) ? rand_span(1 - int'(tol), int'(tol) - 1) : 0;
        return rand_span(lo, hi);
    endfunction

    function tick_item_t mission_tick(bit plan_ok);
        int yaw, ahead, goal;
        yaw = rand_span(-12868, 12868);
        ahead = rand_span(-131072, 131071);
        goal = rand_span(-12868, 12868);
        case (ph)
            0: yaw = pick_error(tol_yaw, -12868, 12868);
            1: ahead = pick_error(tol_dist, -131072, 131071);
            default: goal = pick_error(tol_yaw, -12868, 12868);
        endcase
        return mk_item(ACT_TICK, yaw, ahead, goal, plan_ok, int'($urandom), int'($urandom));
    endfunction

    task automatic send_item(input tick_item_t it);
        if (!steady) begin
            while ($urandom_range(99) < 27) begin
                @(negedge aclk);
                s_valid = 1'b0;
            end
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_action = it.action;
        s_yaw_to_target = it.yaw;
        s_distance_ahead = it.ahead;
        s_goal_yaw_error = it.goal;
        s_plan_valid = it.plan_ok;
        s_plan_linear = it.lin;
        s_plan_angular = it.ang;
        do @(posedge aclk); while (!s_ready);
        tick_results_due.insert(tick_results_due.size(), sequencer_tick(it));
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (tick_results_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_cfg(input cfg_index_t idx, input logic [16:0] val);
        drain_results();
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_wr_index = idx;
        cfg_wr_data = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_KP_YAW:       gain_kp_yaw = val[15:0];
            CFG_KI_YAW:       gain_ki_yaw = val[15:0];
            CFG_KD_YAW:       gain_kd_yaw = val[15:0];
            CFG_KP_DISTANCE:  gain_kp_dist = val[15:0];
            CFG_KI_DISTANCE:  gain_ki_dist = val[15:0];
            CFG_KD_DISTANCE:  gain_kd_dist = val[15:0];
            CFG_YAW_TOL:      tol_yaw = val[13:0];
            CFG_DISTANCE_TOL: tol_dist = val[16:0];
        endcase
    endtask

    task automatic load_gains(input gain_set_t g);
        write_cfg(CFG_KP_YAW, 17'(g.kp_y));
        write_cfg(CFG_KI_YAW, 17'(g.ki_y));
        write_cfg(CFG_KD_YAW, 17'(g.kd_y));
        write_cfg(CFG_KP_DISTANCE, 17'(g.kp_d));
        write_cfg(CFG_KI_DISTANCE, 17'(g.ki_d));
        write_cfg(CFG_KD_DISTANCE, 17'(g.kd_d));
        write_cfg(CFG_YAW_TOL, 17'(g.ytol));
        write_cfg(CFG_DISTANCE_TOL, g.dtol);
    endtask

    task automatic run_mission(input bit starve);
        int ticks, fresh, abort_at;
        fresh = int'($urandom_range(4));
        abort_at = ($urandom_range(99) < 15) ? int'($urandom_range(60)) : -1;
        send_item(mk_item(ACT_START, int'($urandom), int'($urandom), int'($urandom),
                          1'($urandom_range(1)), int'($urandom), int'($urandom)));
        for (ticks = 0; ticks < 150 && run_on; ticks++) begin
            if (ticks == abort_at)
                send_item(mk_item(action_t'($urandom_range(3)), int'($urandom),
                                  int'($urandom), int'($urandom), 1'($urandom_range(1)),
                                  int'($urandom), int'($urandom)));
            else if (starve)
                send_item(mission_tick((ticks < fresh) ? bit'($urandom_range(1)) : 1'b0));
            else
                send_item(mission_tick($urandom_range(99) < 90));
        end
    endtask

    task automatic run_missions(input int budget);
        int target, r;
        target = items_sent + budget;
        while (items_sent < target) begin
            r = int'($urandom_range(99));
            if (r < 70) begin
                run_mission(1'b0);
            end else if (r < 85) begin
                run_mission(1'b1);
            end else begin
                repeat ($urandom_range(4, 1))
                    send_item(mk_item(action_t'($urandom_range(3)), int'($urandom),
                                      int'($urandom), int'($urandom), 1'($urandom_range(1)),
                                      int'($urandom), int'($urandom)));
            end
        end
    endtask

    task automatic test_directed();
        send_item(mk_item(ACT_TICK, 12868, 131071, -12868, 1'b1, 32767, -32768));
        send_item(mk_item(ACT_CANCEL, -12868, -131072, 12868, 1'b1, -1, 1));
        send_item(mk_item(ACT_PREEMPT, 0, 0, 0, 1'b0, 0, 0));
        send_item(mk_item(ACT_START, -1, -1, -1, 1'b1, -1, -1));
        send_item(mk_item(ACT_TICK, 12868, 0, 0, 1'b1, 32767, -32768));
        send_item(mk_item(ACT_TICK, -12868, 0, 0, 1'b0, 5, 5));
        send_item(mk_item(ACT_TICK, YAW_BIG, 0, 0, 1'b1, -32768, 32767));
        send_item(mk_item(ACT_TICK, -YAW_BIG, 0, 0, 1'b1, 100, -100));
        send_item(mk_item(ACT_TICK, YAW_BIG + 1, 0, 0, 1'b1, 7, 7));
        send_item(mk_item(ACT_TICK, 0, 131071, 12868, 1'b1, -32768, 32767));
        send_item(mk_item(ACT_TICK, 204, -131072, -12868, 1'b1, 1, 1));
        send_item(mk_item(ACT_TICK, -205, 0, 0, 1'b0, 2, 2));
        send_item(mk_item(ACT_PREEMPT, 0, 0, 0, 1'b1, 3, 3));
        send_item(mk_item(ACT_TICK, 0, 0, 0, 1'b1, 4, 4));
        send_item(mk_item(ACT_START, 0, 0, 0, 1'b0, 0, 0));
        send_item(mk_item(ACT_TICK, -1, 0, 0, 1'b1, 9, -9));
        send_item(mk_item(ACT_CANCEL, 0, 0, 0, 1'b1, 0, 0));
        send_item(mk_item(ACT_CANCEL, 0, 0, 0, 1'b1, 0, 0));
        send_item(mk_item(ACT_START, 0, 0, 0, 1'b1, 0, 0));
        send_item(mk_item(ACT_TICK, 3000, 0, 0, 1'b1, 11, 12));
        send_item(mk_item(ACT_START, 0, 0, 0, 1'b1, 0, 0));
        send_item(mk_item(ACT_TICK, -3000, 0, 0, 1'b1, 13, 14));
        drain_results();
    endtask

    task automatic test_backpressure();
        stall_request = 1'b1;
        send_item(mk_item(ACT_START, 0, 0, 0, 1'b1, 0, 0));
        repeat (30) send_item(mission_tick(1'b1));
        drain_results();
    endtask

    task automatic test_gain_sweep();
        gain_set_t g;
        int k;
        g = '{16'd410, 16'd4096, 16'd0, 16'd410, 16'd4096, 16'd0, 14'd205, 17'd205};
        load_gains(g);
        run_missions(250);
        g = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 14'd0, 17'd0};
        load_gains(g);
        run_missions(200);
        g = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              14'd12868, 17'd131071};
        load_gains(g);
        run_missions(250);
        g = '{16'd8192, 16'd2000, 16'd2048, 16'd8192, 16'd1228, 16'd2048, 14'd1000,
              17'd8000};
        load_gains(g);
        run_missions(250);
        for (k = 0; k < 3; k++) begin
            g.kp_y = 16'($urandom);
            g.ki_y = 16'($urandom);
            g.kd_y = 16'($urandom);
            g.kp_d = 16'($urandom);
            g.ki_d = (k == 0) ? 16'd1229 : 16'($urandom_range(2500));
            g.kd_d = 16'($urandom);
            g.ytol = 14'($urandom_range(12868));
            g.dtol = 17'($urandom_range(131071));
            load_gains(g);
            run_missions(200);
        end
    endtask

    task automatic test_steady_stream();
        steady = 1'b1;
        run_missions(200);
        drain_results();
        steady = 1'b0;
    endtask

    always @(negedge aclk) begin
        if (stall_request) begin
            stall_left = STALL_CYCLES;
            stall_request = 1'b0;
        end
        if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else begin
            m_ready = steady || ($urandom_range(99) >= 27);
        end
    end

    task automatic compare_field(input string name, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        tick_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (tick_results_due.size() == 0) begin
                $error("result transfer with no expected result pending");
                errors++;
            end else begin
                want = tick_results_due.pop_front();
                compare_field("phase", 64'(want.phase), 64'(m_phase));
                compare_field("ref_linear", 64'(want.ref_lin), 64'(m_ref_linear));
                compare_field("ref_angular", 64'(want.ref_ang), 64'(m_ref_angular));
                compare_field("cmd_linear", 64'(want.cmd_lin), 64'(m_cmd_linear));
                compare_field("cmd_angular", 64'(want.cmd_ang), 64'(m_cmd_angular));
                compare_field("outcome", 64'(want.outcome), 64'(m_outcome));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_index = '0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_action = '0;
        s_yaw_to_target = '0;
        s_distance_ahead = '0;
        s_goal_yaw_error = '0;
        s_plan_valid = 1'b0;
        s_plan_linear = '0;
        s_plan_angular = '0;
        m_ready = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_backpressure();
        test_gain_sweep();
        test_steady_stream();
        drain_results();

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> rotate_drive_rotate_pid_sequencer.f
rtl/rdrp_pkg.sv
rtl/rdrp_yaw_pid.sv
rtl/rdrp_dist_pid.sv
rtl/rotate_drive_rotate_pid_sequencer.sv
test/tb.sv
